@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Simulation builds get checking
// assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SVPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define SVPD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define SVPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SVPD_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ hdl/svpd_pkg.sv @@
package svpd_pkg;

    localparam int DEF_NUM_CHANNELS  = 2;
    localparam int DEF_COUNTER_WIDTH = 16;
    localparam int MAX_CHANNELS      = 2;
    localparam int CFG_DATA_W        = 16;
    localparam int CFG_IDX_W         = 3;
    localparam int ANGLE_W           = 8;
    localparam int PULSE_W           = 8;
    localparam int ANGLE_MAX         = 180;
    localparam int QUEUE_DEPTH       = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TOP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PULSES      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH_A = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH_B = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH_B = CFG_IDX_W'(5);

    localparam logic [CFG_DATA_W-1:0] RST_PERIOD_TOP = CFG_DATA_W'(20000);
    localparam logic [PULSE_W-1:0]    RST_PULSES     = PULSE_W'(50);
    localparam logic [CFG_DATA_W-1:0] RST_MIN_WIDTH  = CFG_DATA_W'(1000);
    localparam logic [CFG_DATA_W-1:0] RST_MAX_WIDTH  = CFG_DATA_W'(2500);

    // Beat kinds.
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    // Division by the full-scale angle is done as a multiply by a scaled
    // reciprocal followed by a one-step correction.
    localparam int PROD_W      = ANGLE_W + CFG_DATA_W;
    localparam int RECIP_SHIFT = PROD_W + 8;
    localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / ANGLE_MAX;
    localparam int RECIP_W     = RECIP_SHIFT - 7;

    typedef struct packed {
        logic [CFG_DATA_W-1:0]                   period_top;
        logic [PULSE_W-1:0]                      pulses;
        logic [MAX_CHANNELS-1:0][CFG_DATA_W-1:0] min_w;
        logic [MAX_CHANNELS-1:0][CFG_DATA_W-1:0] max_w;
    } t_cfg;

    typedef struct packed {
        logic                  kind;
        logic                  channel;
        logic [CFG_DATA_W-1:0] cmp;
    } t_entry;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_qstat;

endpackage

@@ hdl/svpd_if.sv @@
interface svpd_cmd_if;
    import svpd_pkg::*;
    logic               valid;
    logic               ready;
    logic               kind;
    logic               channel;
    logic [ANGLE_W-1:0] angle;
    modport source (output valid, kind, channel, angle, input ready);
    modport sink   (input valid, kind, channel, angle, output ready);
endinterface

interface svpd_res_if;
    logic valid;
    logic ready;
    logic pwm_a;
    logic pwm_b;
    logic running_a;
    logic running_b;
    modport source (output valid, pwm_a, pwm_b, running_a, running_b, input ready);
    modport sink   (input valid, pwm_a, pwm_b, running_a, running_b, output ready);
endinterface

interface svpd_cfg_if;
    import svpd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/svpd_front.sv @@
module svpd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    svpd_cmd_if.sink        i_cmd,
    input  svpd_pkg::t_cfg  i_cfg,
    input  logic            i_pop,
    output logic            o_push,
    output svpd_pkg::t_entry o_entry
);
    import svpd_pkg::*;

    localparam int CREDIT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QW       = CFG_DATA_W + 1;
    localparam int SW       = PROD_W + RECIP_W;

    logic [CREDIT_W-1:0] r_credit, n_credit;
    logic                w_acc;

    // Beats in the pipe or the queue never exceed the queue depth.
    assign i_cmd.ready = (r_credit < CREDIT_W'(QUEUE_DEPTH));
    assign w_acc       = i_cmd.valid && i_cmd.ready;
    assign n_credit    = r_credit + CREDIT_W'(w_acc) - CREDIT_W'(i_pop);

    logic [4:0] r_vld;

    // Stage 1: clamp and span.
    logic                  r_s1_kind, r_s1_ch, r_s1_neg;
    logic [ANGLE_W-1:0]    r_s1_ang;
    logic [CFG_DATA_W-1:0] r_s1_mag, r_s1_lo;
    // Stage 2: product.
    logic                  r_s2_kind, r_s2_ch, r_s2_neg;
    logic [PROD_W-1:0]     r_s2_prod;
    logic [CFG_DATA_W-1:0] r_s2_lo;
    // Stage 3: quotient estimate.
    logic                  r_s3_kind, r_s3_ch, r_s3_neg;
    logic [PROD_W-1:0]     r_s3_prod;
    logic [QW-1:0]         r_s3_qest;
    logic [CFG_DATA_W-1:0] r_s3_lo;
    // Stage 4: corrected quotient.
    logic                  r_s4_kind, r_s4_ch, r_s4_neg;
    logic [QW-1:0]         r_s4_q;
    logic [CFG_DATA_W-1:0] r_s4_lo;
    // Stage 5: compare value.
    t_entry                r_s5;

    logic [ANGLE_W-1:0]    w_ang;
    logic [CFG_DATA_W-1:0] w_lo, w_hi;
    logic                  w_neg;
    logic [SW-1:0]         w_scaled;
    logic [PROD_W-1:0]     w_rem;

    always_comb begin
        w_ang    = (i_cmd.angle > ANGLE_W'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX) : i_cmd.angle;
        w_lo     = i_cfg.min_w[i_cmd.channel];
        w_hi     = i_cfg.max_w[i_cmd.channel];
        w_neg    = (w_hi < w_lo);
        w_scaled = SW'(r_s2_prod) * SW'(RECIP);
        w_rem    = r_s3_prod - PROD_W'(r_s3_qest) * PROD_W'(ANGLE_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
            r_vld    <= '0;
        end else begin
            r_credit <= n_credit;
            r_vld    <= {r_vld[3:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_kind <= i_cmd.kind;
        r_s1_ch   <= i_cmd.channel;
        r_s1_ang  <= w_ang;
        r_s1_neg  <= w_neg;
        r_s1_mag  <= w_neg ? (w_lo - w_hi) : (w_hi - w_lo);
        r_s1_lo   <= w_lo;

        r_s2_kind <= r_s1_kind;
        r_s2_ch   <= r_s1_ch;
        r_s2_neg  <= r_s1_neg;
        r_s2_prod <= PROD_W'(r_s1_ang) * PROD_W'(r_s1_mag);
        r_s2_lo   <= r_s1_lo;

        r_s3_kind <= r_s2_kind;
        r_s3_ch   <= r_s2_ch;
        r_s3_neg  <= r_s2_neg;
        r_s3_prod <= r_s2_prod;
        r_s3_qest <= w_scaled[RECIP_SHIFT +: QW];
        r_s3_lo   <= r_s2_lo;

        // The estimate is at most one below the true quotient.
        r_s4_kind <= r_s3_kind;
        r_s4_ch   <= r_s3_ch;
        r_s4_neg  <= r_s3_neg;
        r_s4_q    <= r_s3_qest + QW'(w_rem >= PROD_W'(ANGLE_MAX));
        r_s4_lo   <= r_s3_lo;

        r_s5.kind    <= r_s4_kind;
        r_s5.channel <= r_s4_ch;
        r_s5.cmp     <= r_s4_neg ? (r_s4_lo - r_s4_q[CFG_DATA_W-1:0])
                                 : (r_s4_lo + r_s4_q[CFG_DATA_W-1:0]);
    end

    assign o_push  = r_vld[4];
    assign o_entry = r_s5;

endmodule

@@ hdl/svpd_queue.sv @@
module svpd_queue #(
    parameter int DEPTH = svpd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  svpd_pkg::t_entry i_entry,
    input  logic             i_pop,
    output svpd_pkg::t_entry o_entry,
    output svpd_pkg::t_qstat o_stat
);
    import svpd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= next_ptr(r_wr);
            if (i_pop)  r_rd <= next_ptr(r_rd);
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    assign o_entry          = r_mem[r_rd];
    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.full      = (r_count == CNT_W'(DEPTH));

endmodule

@@ hdl/svpd_back.sv @@
module svpd_back #(
    parameter int NUM_CHANNELS  = svpd_pkg::DEF_NUM_CHANNELS,
    parameter int COUNTER_WIDTH = svpd_pkg::DEF_COUNTER_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  svpd_pkg::t_qstat i_stat,
    input  svpd_pkg::t_entry i_entry,
    input  svpd_pkg::t_cfg   i_cfg,
    output logic             o_pop,
    svpd_res_if.source       o_res
);
    import svpd_pkg::*;

    logic [COUNTER_WIDTH-1:0]                   r_counter, n_counter;
    logic [NUM_CHANNELS-1:0][COUNTER_WIDTH-1:0] r_pend, n_pend, r_act, n_act;
    logic [NUM_CHANNELS-1:0][PULSE_W-1:0]       r_cnt, n_cnt;
    logic [NUM_CHANNELS-1:0]                    r_en, n_en, r_lvl, n_lvl;
    logic [MAX_CHANNELS-1:0]                    w_lvl_pad, w_en_pad;
    logic                                       r_out_valid;
    logic [MAX_CHANNELS-1:0]                    r_out_pwm, r_out_run;

    assign o_pop = i_stat.not_empty && (!r_out_valid || o_res.ready);

    always_comb begin
        n_counter = r_counter;
        n_pend    = r_pend;
        n_act     = r_act;
        n_cnt     = r_cnt;
        n_en      = r_en;
        n_lvl     = r_lvl;
        if (i_entry.kind == KIND_TICK) begin
            n_counter = (r_counter >= i_cfg.period_top[COUNTER_WIDTH-1:0])
                      ? '0 : r_counter + COUNTER_WIDTH'(1);
        end
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (i_entry.kind == KIND_TICK) begin
                if (r_counter == '0) begin
                    n_act[c] = r_pend[c];
                    if (r_en[c]) n_lvl[c] = 1'b1;
                end
                if (r_en[c] && (r_counter == n_act[c])) begin
                    n_lvl[c] = 1'b0;
                    n_cnt[c] = r_cnt[c] + PULSE_W'(1);
                    if (n_cnt[c] >= i_cfg.pulses) begin
                        n_en[c]  = 1'b0;
                        n_cnt[c] = '0;
                    end
                end
                if (!n_en[c]) n_lvl[c] = 1'b0;
            end else if (i_entry.channel == 1'(c)) begin
                n_pend[c] = i_entry.cmp[COUNTER_WIDTH-1:0];
                n_en[c]   = 1'b1;
            end
        end
        w_lvl_pad                   = '0;
        w_en_pad                    = '0;
        w_lvl_pad[NUM_CHANNELS-1:0] = n_lvl;
        w_en_pad[NUM_CHANNELS-1:0]  = n_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter   <= '0;
            r_pend      <= '0;
            r_act       <= '0;
            r_cnt       <= '0;
            r_en        <= '0;
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_counter <= n_counter;
                r_pend    <= n_pend;
                r_act     <= n_act;
                r_cnt     <= n_cnt;
                r_en      <= n_en;
                r_lvl     <= n_lvl;
            end
            if (o_pop)            r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_pwm <= w_lvl_pad;
            r_out_run <= w_en_pad;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.pwm_a     = r_out_pwm[0];
    assign o_res.pwm_b     = r_out_pwm[1];
    assign o_res.running_a = r_out_run[0];
    assign o_res.running_b = r_out_run[1];

endmodule

@@ hdl/servo_pwm_angle_driver.sv @@
// Channel  Dir  Beat carries                                 Accepted when
// i_cmd    in   kind, channel, angle                         valid && ready
// i_cfg    in   index, data (register write)                 valid && ready
// o_res    out  pwm_a, pwm_b, running_a, running_b           valid && ready
//
// One beat is accepted per cycle while i_cmd ready is high. Each beat passes
// through the five-stage angle mapping pipe, which loads its first stage on the
// accepting edge, then through the queue and into the result register. A credit
// count lets up to eight beats sit in the pipe and the queue together, and one
// more may wait in the result register.
// Reset is synchronous and active low; it restores the register defaults.
// When o_res stalls, the result register holds and the queue fills; i_cmd
// ready drops once eight beats sit in the pipe and the queue.
`include "assert_macros.svh"

module servo_pwm_angle_driver #(
    parameter int NUM_CHANNELS  = svpd_pkg::DEF_NUM_CHANNELS,
    parameter int COUNTER_WIDTH = svpd_pkg::DEF_COUNTER_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    svpd_cmd_if.sink   i_cmd,
    svpd_cfg_if.sink   i_cfg,
    svpd_res_if.source o_res
);
    import svpd_pkg::*;

    // Configuration registers. The user must write them only while the block is
    // idle; the block does not enforce this. Both parts may read them directly.
    t_cfg   r_cfg;
    t_entry w_push_entry, w_head_entry;
    t_qstat w_qstat;
    logic   w_push, w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_top <= RST_PERIOD_TOP;
            r_cfg.pulses     <= RST_PULSES;
            r_cfg.min_w      <= {MAX_CHANNELS{RST_MIN_WIDTH}};
            r_cfg.max_w      <= {MAX_CHANNELS{RST_MAX_WIDTH}};
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PERIOD_TOP:  r_cfg.period_top <= i_cfg.data;
                CFG_PULSES:      r_cfg.pulses     <= i_cfg.data[PULSE_W-1:0];
                CFG_MIN_WIDTH_A: r_cfg.min_w[0]   <= i_cfg.data;
                CFG_MAX_WIDTH_A: r_cfg.max_w[0]   <= i_cfg.data;
                CFG_MIN_WIDTH_B: r_cfg.min_w[1]   <= i_cfg.data;
                CFG_MAX_WIDTH_B: r_cfg.max_w[1]   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // The front part classifies each beat and, for angle commands, maps the
    // angle to a compare value in a pipeline; ticks ride along unchanged.
    svpd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_cfg   (r_cfg),
        .i_pop   (w_pop),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    // The queue keeps beats in order between mapping and execution.
    svpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_stat  (w_qstat)
    );

    // The back part owns the period counter and channel state, applies one beat per
    // cycle while the queue holds beats and o_res is not stalled, and registers the resulting levels.
    svpd_back #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_qstat),
        .i_entry (w_head_entry),
        .i_cfg   (r_cfg),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

    // The credit count in the front must keep the queue from overflowing.
    `SVPD_ASSERT_NEVER(a_queue_no_overflow, i_clk, i_rst_n, w_push && w_qstat.full && !w_pop)
    // A stopped channel never drives its output high.
    `SVPD_ASSERT_IMPL(a_pwm_a_stopped_low, i_clk, i_rst_n, o_res.valid, !o_res.pwm_a || o_res.running_a)
    `SVPD_ASSERT_IMPL(a_pwm_b_stopped_low, i_clk, i_rst_n, o_res.valid, !o_res.pwm_b || o_res.running_b)
    // With work queued and an empty result register, the back part must take it.
    `SVPD_ASSERT_IMPL(a_back_no_idle, i_clk, i_rst_n, w_qstat.not_empty && !o_res.valid, w_pop)

endmodule
